// ===== rtl/core/awcg_pkg.sv =====
// ----------------------------------------------------------------------------
// awcg_pkg
// Shared types, constants and the control program of the worker count governor.
// ----------------------------------------------------------------------------
package awcg_pkg;

  localparam int unsigned WorkerLimitDefault = 8;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ADAPTIVE_ENABLE = 2'd0,
    REG_MANUAL_WORKERS  = 2'd1,
    REG_MIN_WORKERS     = 2'd2,
    REG_MAX_WORKERS     = 2'd3
  } cfg_reg_e;

  localparam logic       ResetEnable = 1'b1;
  localparam logic [3:0] ResetManual = 4'd4;
  localparam logic [3:0] ResetMin    = 4'd1;
  localparam logic [3:0] ResetMax    = 4'd8;
  localparam logic [3:0] ResetActive = 4'd4;

  // Payload of the two channels
  typedef struct packed {
    logic [15:0] busy_time;
    logic [15:0] deadline_time;
    logic [7:0]  task_count;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  worker_count;
    logic [15:0] smoothed_load;
    logic [15:0] peak_load;
    logic        report_applied;
  } out_item_t;

  // Load arithmetic, Q8.8 percent
  localparam logic [31:0] CurScale    = 32'd25600;
  localparam logic [22:0] SatScale    = 23'd100;
  localparam logic [31:0] EmaWeight   = 32'd19;
  localparam logic [15:0] EmaDivisor  = 16'd20;
  localparam logic [31:0] PeakWeight  = 32'd99;
  localparam logic [15:0] PeakDivisor = 16'd100;
  localparam logic [15:0] LoadMax     = 16'hFFFF;
  localparam logic [15:0] EmaSeedMax  = 16'd2;

  localparam logic [15:0] EmaHigh   = 16'd15360;
  localparam logic [15:0] PeakHigh  = 16'd17920;
  localparam logic [15:0] PeakEmerg = 16'd21760;
  localparam logic [15:0] EmaLow    = 16'd7680;

  // Busy/deadline ratio tests: busy*10 against deadline*k
  localparam logic [19:0] RatioScale = 20'd10;
  localparam logic [19:0] RatioHigh  = 20'd6;
  localparam logic [19:0] RatioEmerg = 20'd8;
  localparam logic [19:0] RatioMid   = 20'd4;
  localparam logic [19:0] RatioLow   = 20'd3;

  // Run counters and scaling steps
  localparam logic [4:0] HighRunUp   = 5'd4;
  localparam logic [4:0] HighRunMid  = 5'd8;
  localparam logic [9:0] LowRunLimit = 10'd300;
  localparam logic [3:0] ScaleStep   = 4'd2;
  localparam logic [3:0] MidTarget   = 4'd4;

  // Task count floor
  localparam logic [7:0] TaskHigh  = 8'd16;
  localparam logic [7:0] TaskMid   = 8'd8;
  localparam logic [3:0] FloorHigh = 4'd6;
  localparam logic [3:0] FloorMid  = 4'd4;
  localparam logic [3:0] FloorLow  = 4'd2;

  // Shared divider: 16-bit quotient, a few quotient bits per cycle
  localparam int unsigned DivQBits        = 16;
  localparam int unsigned DivBitsPerCycle = 2;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [15:0] quotient;
  } div_rsp_t;

  // Sequencer program
  localparam int unsigned PcW = 4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_START_CUR,
    OP_SET_CUR,
    OP_START_EMA,
    OP_SET_EMA,
    OP_START_PEAK,
    OP_SET_PEAK,
    OP_DECIDE,
    OP_MANUAL,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_IN,
    C_DIV_BUSY,
    C_OUT_FULL,
    C_DISABLED,
    C_DL_ZERO
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          wait_c;
    cond_e          jump_c;
    logic [PcW-1:0] target;
  } ctrl_t;

  localparam logic [PcW-1:0] P_IDLE     = 4'd0;
  localparam logic [PcW-1:0] P_MODE     = 4'd1;
  localparam logic [PcW-1:0] P_ZERO     = 4'd2;
  localparam logic [PcW-1:0] P_CUR      = 4'd3;
  localparam logic [PcW-1:0] P_CUR_END  = 4'd4;
  localparam logic [PcW-1:0] P_EMA      = 4'd5;
  localparam logic [PcW-1:0] P_EMA_END  = 4'd6;
  localparam logic [PcW-1:0] P_PEAK     = 4'd7;
  localparam logic [PcW-1:0] P_PEAK_END = 4'd8;
  localparam logic [PcW-1:0] P_DECIDE   = 4'd9;
  localparam logic [PcW-1:0] P_MANUAL   = 4'd10;
  localparam logic [PcW-1:0] P_OUT      = 4'd11;

  // The op of a step runs in the cycle its wait condition is false; the step
  // then jumps to its target if the jump condition holds, else falls through.
  function automatic ctrl_t prog_word(input logic [PcW-1:0] pc);
    ctrl_t w;
    case (pc)
      P_IDLE:     w = '{op: OP_ACCEPT,     wait_c: C_NO_IN,    jump_c: C_NONE,     target: P_IDLE};
      P_MODE:     w = '{op: OP_NOP,        wait_c: C_NONE,     jump_c: C_DISABLED, target: P_MANUAL};
      P_ZERO:     w = '{op: OP_NOP,        wait_c: C_NONE,     jump_c: C_DL_ZERO,  target: P_OUT};
      P_CUR:      w = '{op: OP_START_CUR,  wait_c: C_NONE,     jump_c: C_NONE,     target: P_IDLE};
      P_CUR_END:  w = '{op: OP_SET_CUR,    wait_c: C_DIV_BUSY, jump_c: C_NONE,     target: P_IDLE};
      P_EMA:      w = '{op: OP_START_EMA,  wait_c: C_NONE,     jump_c: C_NONE,     target: P_IDLE};
      P_EMA_END:  w = '{op: OP_SET_EMA,    wait_c: C_DIV_BUSY, jump_c: C_NONE,     target: P_IDLE};
      P_PEAK:     w = '{op: OP_START_PEAK, wait_c: C_NONE,     jump_c: C_NONE,     target: P_IDLE};
      P_PEAK_END: w = '{op: OP_SET_PEAK,   wait_c: C_DIV_BUSY, jump_c: C_NONE,     target: P_IDLE};
      P_DECIDE:   w = '{op: OP_DECIDE,     wait_c: C_NONE,     jump_c: C_ALWAYS,   target: P_OUT};
      P_MANUAL:   w = '{op: OP_MANUAL,     wait_c: C_NONE,     jump_c: C_NONE,     target: P_IDLE};
      P_OUT:      w = '{op: OP_EMIT,       wait_c: C_OUT_FULL, jump_c: C_ALWAYS,   target: P_IDLE};
      default:    w = '{op: OP_NOP,        wait_c: C_NONE,     jump_c: C_ALWAYS,   target: P_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/awcg_div.sv =====
// ----------------------------------------------------------------------------
// awcg_div
// Restoring divider with a 16-bit quotient, a few quotient bits per cycle.
// The upper half of the dividend must be below the divisor.
// ----------------------------------------------------------------------------
module awcg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  awcg_pkg::div_req_t req_i,
  output awcg_pkg::div_rsp_t rsp_o
);
  import awcg_pkg::*;

  localparam int unsigned Iters = DivQBits / DivBitsPerCycle;
  localparam int unsigned CntW  = $clog2(Iters + 1);

  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DivQBits-1:0] rem_q, rem_d;
  logic [DivQBits-1:0] quo_q, quo_d;
  logic [DivQBits-1:0] dsr_q, dsr_d;

  always_comb begin : step_logic
    logic [DivQBits:0]   trial;
    logic [DivQBits-1:0] r;
    logic [DivQBits-1:0] q;
    logic                ge;
    r     = rem_q;
    q     = quo_q;
    trial = '0;
    ge    = 1'b0;
    for (int i = 0; i < DivBitsPerCycle; i++) begin
      trial = {r, q[DivQBits-1]};
      ge    = (trial >= {1'b0, dsr_q});
      r     = ge ? DivQBits'(trial - {1'b0, dsr_q}) : trial[DivQBits-1:0];
      q     = {q[DivQBits-2:0], ge};
    end

    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dsr_d = dsr_q;
    if (req_i.start) begin
      cnt_d = CntW'(Iters);
      rem_d = req_i.dividend[31:16];
      quo_d = req_i.dividend[15:0];
      dsr_d = req_i.divisor;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CntW'(1);
      rem_d = r;
      quo_d = q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy     = (cnt_q != '0);
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/core/adaptive_worker_count_governor_top.sv =====
// ----------------------------------------------------------------------------
// adaptive_worker_count_governor_top
// Worker count governor: load, smoothed load and peak from one report per block.
// ----------------------------------------------------------------------------
// One report is worked on at a time by a small microcoded sequencer. A report
// with adaptation enabled and a nonzero deadline runs three divisions (load,
// smoothed load, peak decay) one after another on a single shared divider that
// retires two quotient bits per cycle, then the scaling decision, before its
// result is written to the output register. A zero-deadline report skips the
// divisions and the decision; with adaptation disabled, the clamped manual count
// is taken instead. The next report is taken as soon as the sequencer is back
// at its idle step, even while the last result still waits in the output register.
module adaptive_worker_count_governor_top #(
  parameter int unsigned WorkerLimit = awcg_pkg::WorkerLimitDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [awcg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [awcg_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  awcg_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output awcg_pkg::out_item_t           out_data_o
);
  import awcg_pkg::*;

  // Wide enough for the limit itself and for a count raised by one step.
  localparam int unsigned LimW = $clog2(WorkerLimit + 1);
  localparam int unsigned TW   = (LimW > 5) ? LimW : 5;

  // Configuration
  logic       en_q;
  logic [3:0] manual_q, min_q, max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= ResetEnable;
      manual_q <= ResetManual;
      min_q    <= ResetMin;
      max_q    <= ResetMax;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ADAPTIVE_ENABLE: en_q     <= cfg_data_i[0];
        REG_MANUAL_WORKERS:  manual_q <= cfg_data_i;
        REG_MIN_WORKERS:     min_q    <= cfg_data_i;
        REG_MAX_WORKERS:     max_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  logic [PcW-1:0] pc_q, pc_d;
  ctrl_t          cw;
  logic           wait_now, jump_now, exec;
  div_req_t       div_req;
  div_rsp_t       div_rsp;

  logic out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  in_item_t    in_q, in_d;
  logic [15:0] cur_q, cur_d;
  logic        sat_q, sat_d;
  logic        r60_q, r60_d, r80_q, r80_d, r40_q, r40_d, r30_q, r30_d;

  logic [3:0]  active_q, active_d;
  logic [15:0] ema_q, ema_d;
  logic [15:0] peak_q, peak_d;
  logic [3:0]  high_run_q, high_run_d;
  logic [8:0]  low_run_q, low_run_d;
  logic        applied_q, applied_d;

  function automatic logic cond_true(input cond_e c, input logic valid, input logic busy,
                                     input logic out_full, input logic en,
                                     input logic dl_zero);
    logic r;
    case (c)
      C_NONE:     r = 1'b0;
      C_ALWAYS:   r = 1'b1;
      C_NO_IN:    r = !valid;
      C_DIV_BUSY: r = busy;
      C_OUT_FULL: r = out_full;
      C_DISABLED: r = !en;
      C_DL_ZERO:  r = dl_zero;
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [TW-1:0] clamp_w(input logic [TW-1:0] v, input logic [TW-1:0] lo,
                                            input logic [TW-1:0] hi);
    logic [TW-1:0] r;
    r = v;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  logic out_full, dl_zero;
  assign out_full = out_valid_q && !out_ready_i;
  assign dl_zero  = (in_q.deadline_time == '0);

  always_comb begin
    cw       = prog_word(pc_q);
    wait_now = cond_true(cw.wait_c, in_valid_i, div_rsp.busy, out_full, en_q, dl_zero);
    jump_now = cond_true(cw.jump_c, in_valid_i, div_rsp.busy, out_full, en_q, dl_zero);
    exec     = !wait_now;
    if (wait_now) begin
      pc_d = pc_q;
    end else if (jump_now) begin
      pc_d = cw.target;
    end else begin
      pc_d = pc_q + PcW'(1);
    end
  end

  assign in_ready_o = (pc_q == P_IDLE);

  // Shared divider
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = 32'(in_q.busy_time) * CurScale;
    div_req.divisor  = in_q.deadline_time;
    if (exec) begin
      case (cw.op)
        OP_START_CUR: begin
          div_req.start = 1'b1;
        end
        OP_START_EMA: begin
          div_req.start    = 1'b1;
          div_req.dividend = 32'(ema_q) * EmaWeight + 32'(cur_q);
          div_req.divisor  = EmaDivisor;
        end
        OP_START_PEAK: begin
          div_req.start    = 1'b1;
          div_req.dividend = 32'(peak_q) * PeakWeight;
          div_req.divisor  = PeakDivisor;
        end
        default: ;
      endcase
    end
  end

  awcg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Load flags of the captured report
  logic [22:0] busy_x100;
  logic [19:0] busy_x10;
  logic        sat_now;
  assign busy_x100 = 23'(in_q.busy_time) * SatScale;
  assign busy_x10  = 20'(in_q.busy_time) * RatioScale;
  // busy*25600/deadline saturates exactly when busy*100 >= deadline*256.
  assign sat_now   = ({1'b0, busy_x100[22:8]} >= in_q.deadline_time);

  // Effective ceiling and clamped manual count
  logic [TW-1:0] emax, man_active;
  assign emax       = (TW'(max_q) > TW'(WorkerLimit)) ? TW'(WorkerLimit) : TW'(max_q);
  assign man_active = clamp_w(TW'(manual_q), TW'(min_q), emax);

  // Scaling decision on the freshly updated smoothed load and peak
  logic [3:0] dec_active;
  logic [3:0] dec_high;
  logic [8:0] dec_low;

  always_comb begin : decide_logic
    logic [TW-1:0] act, tgt, up, down, flr;
    logic [4:0]    hr_inc;
    logic [9:0]    lr_inc;
    act    = TW'(active_q);
    tgt    = act;
    up     = act + TW'(ScaleStep);
    down   = (act >= TW'(ScaleStep)) ? act - TW'(ScaleStep) : '0;
    hr_inc = {1'b0, high_run_q} + 5'd1;
    lr_inc = {1'b0, low_run_q} + 10'd1;
    if (in_q.task_count >= TaskHigh) begin
      flr = TW'(FloorHigh);
    end else if (in_q.task_count >= TaskMid) begin
      flr = TW'(FloorMid);
    end else begin
      flr = TW'(FloorLow);
    end
    dec_high = high_run_q;
    dec_low  = low_run_q;

    if (r60_q || ema_q > EmaHigh || peak_q > PeakHigh) begin
      dec_low = '0;
      if (hr_inc >= HighRunUp) begin
        if (r80_q || peak_q > PeakEmerg) begin
          tgt = TW'(WorkerLimit);
        end else begin
          tgt = (up < emax) ? up : emax;
        end
        dec_high = '0;
      end else begin
        dec_high = 4'(hr_inc);
      end
    end else if (r40_q && act < TW'(MidTarget)) begin
      if (hr_inc >= HighRunMid) begin
        tgt      = TW'(MidTarget);
        dec_high = '0;
      end else begin
        dec_high = 4'(hr_inc);
      end
    end else if (r30_q && ema_q < EmaLow) begin
      dec_high = '0;
      if (lr_inc >= LowRunLimit) begin
        if (act > flr) begin
          tgt = (down > flr) ? down : flr;
        end
        dec_low = '0;
      end else begin
        dec_low = 9'(lr_inc);
      end
    end else begin
      dec_high = '0;
      dec_low  = '0;
    end

    tgt = clamp_w(tgt, TW'(min_q), emax);
    if (tgt < flr) tgt = flr;
    dec_active = 4'(tgt);
  end

  // Datapath actions
  always_comb begin
    in_d        = in_q;
    cur_d       = cur_q;
    sat_d       = sat_q;
    r60_d       = r60_q;
    r80_d       = r80_q;
    r40_d       = r40_q;
    r30_d       = r30_q;
    active_d    = active_q;
    ema_d       = ema_q;
    peak_d      = peak_q;
    high_run_d  = high_run_q;
    low_run_d   = low_run_q;
    applied_d   = applied_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (exec) begin
      case (cw.op)
        OP_ACCEPT: begin
          in_d      = in_data_i;
          applied_d = 1'b0;
        end
        OP_START_CUR: begin
          sat_d = sat_now;
          r60_d = busy_x10 > 20'(in_q.deadline_time) * RatioHigh;
          r80_d = busy_x10 > 20'(in_q.deadline_time) * RatioEmerg;
          r40_d = busy_x10 > 20'(in_q.deadline_time) * RatioMid;
          r30_d = busy_x10 < 20'(in_q.deadline_time) * RatioLow;
        end
        OP_SET_CUR: begin
          cur_d = sat_q ? LoadMax : div_rsp.quotient;
        end
        OP_SET_EMA: begin
          ema_d = (ema_q <= EmaSeedMax) ? cur_q : div_rsp.quotient;
        end
        OP_SET_PEAK: begin
          peak_d = (cur_q > div_rsp.quotient) ? cur_q : div_rsp.quotient;
        end
        OP_DECIDE: begin
          active_d   = dec_active;
          high_run_d = dec_high;
          low_run_d  = dec_low;
          applied_d  = 1'b1;
        end
        OP_MANUAL: begin
          active_d = 4'(man_active);
        end
        OP_EMIT: begin
          out_valid_d = 1'b1;
          out_d       = '{worker_count:   active_q,
                          smoothed_load:  ema_q,
                          peak_load:      peak_q,
                          report_applied: applied_q};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= P_IDLE;
      out_valid_q <= 1'b0;
      active_q    <= ResetActive;
      ema_q       <= '0;
      peak_q      <= '0;
      high_run_q  <= '0;
      low_run_q   <= '0;
      applied_q   <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      active_q    <= active_d;
      ema_q       <= ema_d;
      peak_q      <= peak_d;
      high_run_q  <= high_run_d;
      low_run_q   <= low_run_d;
      applied_q   <= applied_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    cur_q <= cur_d;
    sat_q <= sat_d;
    r60_q <= r60_d;
    r80_q <= r80_d;
    r40_q <= r40_d;
    r30_q <= r30_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The divider is only kicked off when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // While the divider runs, the sequencer sits at a step that waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (pc_q == P_CUR_END || pc_q == P_EMA_END || pc_q == P_PEAK_END))
    else $error("divider running outside a wait step");

  // A new result appears only from the emit step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pc_q) == P_OUT)
    else $error("result raised outside the emit step");

  // An applied report never leaves fewer workers than the smallest task floor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && cw.op == OP_DECIDE) |=> active_q >= FloorLow)
    else $error("worker count below task floor after decision");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Worker count governor testbench
// Sends load reports through the input channel, predicts each status word
// from a behavioral copy of the governor, and checks every status transfer
// field by field. Both channels idle at random, and the run covers several
// register settings, including crossed and out-of-range limits.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import awcg_pkg::*;

  typedef enum int {
    LOAD_QUIET,
    LOAD_MID,
    LOAD_HIGH,
    LOAD_OVER,
    LOAD_EDGE,
    LOAD_NOISE
  } load_kind_e;

  localparam int unsigned CountCeiling = WorkerLimitDefault;
  localparam int WatchdogLimit   = 4000;
  localparam int BackpressureAt  = 150;
  localparam int BackpressureLen = 400;
  localparam int DrainCycles     = 40;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = REG_ADAPTIVE_ENABLE;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;

  adaptive_worker_count_governor_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Register shadow, as last written.
  logic       cfg_enable = 1'b1;
  logic [3:0] cfg_manual = 4'd4;
  logic [3:0] cfg_min    = 4'd1;
  logic [3:0] cfg_max    = 4'd8;

  // Governor state as predicted.
  logic [3:0]  gov_active   = 4'd4;
  logic [15:0] gov_ema      = 16'd0;
  logic [15:0] gov_peak     = 16'd0;
  logic [3:0]  busy_streak  = 4'd0;
  logic [8:0]  quiet_streak = 9'd0;

  in_item_t  report_queue[$];
  out_item_t expected_status[$];

  int  fail_count = 0;
  int  results_seen = 0;
  int  send_gap = 0;
  int  ready_gap = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;
  bit  steady_flow = 1'b0;

  // Appends one report to the tail of the pending queue.
  function automatic void add_report(in_item_t r);
    report_queue.insert(report_queue.size(), r);
  endfunction

  function automatic logic [3:0] ceiling_count();
    return (cfg_max > CountCeiling) ? 4'(CountCeiling) : cfg_max;
  endfunction

  function automatic logic [3:0] clamp_count(logic [3:0] v);
    if (v < cfg_min) v = cfg_min;
    if (v > ceiling_count()) v = ceiling_count();
    return v;
  endfunction

  // Advances the predicted governor by one report and returns its status word.
  function automatic out_item_t apply_report(in_item_t rep);
    out_item_t   res;
    logic [31:0] busy, dl, load_full, decayed;
    logic [15:0] cur;
    logic [3:0]  floor_w, act, target;
    logic        over60, over80, over40, under30;
    res.report_applied = 1'b0;
    if (!cfg_enable) begin
      gov_active = clamp_count(cfg_manual);
    end else if (rep.deadline_time != 16'd0) begin
      busy = 32'(rep.busy_time);
      dl   = 32'(rep.deadline_time);
      load_full = (busy * 32'd25600) / dl;
      cur = (load_full > 32'd65535) ? 16'hFFFF : load_full[15:0];
      // Ratio tests are exact: busy*10 against deadline*k.
      over60  = busy * 10 > dl * 6;
      over80  = busy * 10 > dl * 8;
      over40  = busy * 10 > dl * 4;
      under30 = busy * 10 < dl * 3;
      res.report_applied = 1'b1;
      if (gov_ema <= 16'd2) gov_ema = cur;
      else gov_ema = 16'((32'd19 * gov_ema + cur) / 32'd20);
      decayed = (32'd99 * gov_peak) / 32'd100;
      gov_peak = (32'(cur) > decayed) ? cur : decayed[15:0];
      if (rep.task_count >= 8'd16) floor_w = 4'd6;
      else if (rep.task_count >= 8'd8) floor_w = 4'd4;
      else floor_w = 4'd2;
      act = gov_active;
      target = act;
      if (over60 || gov_ema > 16'd15360 || gov_peak > 16'd17920) begin
        busy_streak = busy_streak + 4'd1;
        quiet_streak = '0;
        if (busy_streak >= 4'd4) begin
          if (over80 || gov_peak > 16'd21760) target = 4'(CountCeiling);
          else target = (act + 2 < ceiling_count()) ? act + 4'd2 : ceiling_count();
          busy_streak = '0;
        end
      end else if (over40 && act < 4'd4) begin
        busy_streak = busy_streak + 4'd1;
        if (busy_streak >= 4'd8) begin
          target = 4'd4;
          busy_streak = '0;
        end
      end else if (under30 && gov_ema < 16'd7680) begin
        quiet_streak = quiet_streak + 9'd1;
        busy_streak = '0;
        if (quiet_streak >= 9'd300) begin
          if (act > floor_w) begin
            target = (act >= 4'd2) ? act - 4'd2 : 4'd0;
            if (target < floor_w) target = floor_w;
          end
          quiet_streak = '0;
        end
      end else begin
        quiet_streak = '0;
        busy_streak = '0;
      end
      target = clamp_count(target);
      if (target < floor_w) target = floor_w;
      gov_active = target;
    end
    res.worker_count  = gov_active;
    res.smoothed_load = gov_ema;
    res.peak_load     = gov_peak;
    return res;
  endfunction

  function automatic in_item_t report_of(int busy, int dl, int tasks);
    in_item_t r;
    r.busy_time     = 16'(busy);
    r.deadline_time = 16'(dl);
    r.task_count    = 8'(tasks);
    return r;
  endfunction

  function automatic in_item_t make_report(load_kind_e kind, int band);
    in_item_t    r;
    logic [31:0] dl, busy, m;
    if ($urandom_range(0, 99) < 80) dl = $urandom_range(1000, 65535);
    else dl = $urandom_range(1, 999);
    case (kind)
      LOAD_QUIET: busy = dl * $urandom_range(0, 279) / 1000;
      LOAD_MID:   busy = dl * $urandom_range(300, 599) / 1000;
      LOAD_HIGH:  busy = dl * $urandom_range(600, 999) / 1000;
      LOAD_OVER:  busy = dl * $urandom_range(1000, 4000) / 1000;
      default: begin
        // Busy time at three to eight tenths of the deadline, or one off either side.
        m = $urandom_range(1, 6553);
        dl = m * 10;
        busy = m * $urandom_range(3, 8) + $urandom_range(0, 2) - 1;
      end
    endcase
    if (busy > 32'd65535) busy = 32'd65535;
    r.busy_time     = busy[15:0];
    r.deadline_time = dl[15:0];
    case (band)
      0:       r.task_count = 8'($urandom_range(0, 7));
      1:       r.task_count = 8'($urandom_range(8, 15));
      default: r.task_count = 8'($urandom_range(16, 255));
    endcase
    if (kind == LOAD_NOISE) begin
      r.busy_time     = 16'($urandom_range(0, 65535));
      r.deadline_time = ($urandom_range(0, 6) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
      r.task_count    = 8'($urandom_range(0, 255));
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic queue_segment(load_kind_e kind, int band, int count);
    repeat (count) add_report(make_report(kind, band));
  endtask

  // Runs of reports with one load level each, so the run counters get going.
  task automatic queue_mixed(int count, int mid_pct);
    int         left, seg, pick, band;
    load_kind_e kind;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < mid_pct) kind = LOAD_MID;
      else if (pick < mid_pct + 25) kind = LOAD_QUIET;
      else if (pick < mid_pct + 45) kind = LOAD_HIGH;
      else if (pick < mid_pct + 55) kind = LOAD_OVER;
      else if (pick < mid_pct + 70) kind = LOAD_EDGE;
      else kind = LOAD_NOISE;
      pick = $urandom_range(0, 99);
      band = (pick < 60) ? 0 : ((pick < 80) ? 1 : 2);
      seg = $urandom_range(1, 30);
      if (seg > left) seg = left;
      queue_segment(kind, band, seg);
      left -= seg;
    end
  endtask

  task automatic wait_drained();
    while (report_queue.size() != 0 || in_valid_i || expected_status.size() != 0)
      @(posedge clk_i);
  endtask

  // Waits until the governor is idle, then writes all four registers.
  task automatic begin_phase(logic en, logic [3:0] man, logic [3:0] mn, logic [3:0] mx);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_ADAPTIVE_ENABLE;
    cfg_data_i <= {3'b000, en};
    @(posedge clk_i);
    cfg_idx_i  <= REG_MANUAL_WORKERS;
    cfg_data_i <= man;
    @(posedge clk_i);
    cfg_idx_i  <= REG_MIN_WORKERS;
    cfg_data_i <= mn;
    @(posedge clk_i);
    cfg_idx_i  <= REG_MAX_WORKERS;
    cfg_data_i <= mx;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_enable = en;
    cfg_manual = man;
    cfg_min    = mn;
    cfg_max    = mx;
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Sender: presents queued reports and records the prediction on each transfer.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_status.insert(expected_status.size(), apply_report(in_data_i));
      end
      if (in_valid_i && !in_ready_o) begin
        // Hold the offered report until it is taken.
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (report_queue.size() > 0) begin
        in_data_i  <= report_queue.pop_front();
        in_valid_i <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: checks each status transfer and stalls at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_status.size() == 0) begin
          $error("status transfer with no report outstanding");
          fail_count++;
        end else begin
          out_item_t want;
          want = expected_status.pop_front();
          check_field("worker_count", 16'(want.worker_count), 16'(out_data_o.worker_count));
          check_field("smoothed_load", want.smoothed_load, out_data_o.smoothed_load);
          check_field("peak_load", want.peak_load, out_data_o.peak_load);
          check_field("report_applied", 16'(want.report_applied),
                      16'(out_data_o.report_applied));
        end
        results_seen++;
        // One long hold-off so the governor backs up and stalls its input.
        if (results_seen == BackpressureAt) hold_left = BackpressureLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) ready_gap = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("** adaptive_worker_count_governor_top: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero deadlines, saturation, exact ratio thresholds, task floors.
    begin_phase(1'b1, 4'd4, 4'd1, 4'd8);
    add_report(report_of(0, 0, 0));
    add_report(report_of(65535, 0, 255));
    add_report(report_of(0, 1, 0));
    add_report(report_of(65535, 1, 255));
    add_report(report_of(65535, 65535, 16));
    add_report(report_of(6, 10, 7));
    add_report(report_of(8, 10, 8));
    add_report(report_of(4, 10, 15));
    add_report(report_of(3, 10, 0));
    add_report(report_of(2999, 10000, 3));
    add_report(report_of(6001, 10000, 3));
    add_report(report_of(8001, 10000, 3));
    add_report(report_of(1, 65535, 3));
    add_report(report_of(9000, 10000, 3));
    add_report(report_of(9000, 10000, 3));
    add_report(report_of(32768, 65535, 128));

    // Adaptation off: manual count above range, at zero, and with crossed limits.
    begin_phase(1'b0, 4'd12, 4'd2, 4'd6);
    add_report(report_of(0, 0, 0));
    add_report(report_of(900, 1000, 20));
    add_report(report_of(65535, 65535, 255));
    begin_phase(1'b0, 4'd0, 4'd0, 4'd0);
    add_report(report_of(100, 1000, 0));
    add_report(report_of(5, 0, 9));
    begin_phase(1'b0, 4'd5, 4'd7, 4'd3);
    add_report(report_of(500, 1000, 2));
    add_report(report_of(500, 1000, 2));

    // Random reports under a range of settings.
    begin_phase(1'b1, 4'd4, 4'd1, 4'd8);
    queue_mixed(250, 20);
    begin_phase(1'b1, 4'd4, 4'd1, 4'd3);
    queue_mixed(170, 45);
    // Overload drives the count up, then a long quiet stretch lets it come down.
    begin_phase(1'b1, 4'd4, 4'd2, 4'd15);
    queue_segment(LOAD_OVER, 0, 12);
    queue_segment(LOAD_QUIET, 0, 450);
    begin_phase(1'b1, 4'd8, 4'd6, 4'd4);
    queue_mixed(150, 20);
    begin_phase(1'b0, 4'd15, 4'd0, 4'd15);
    queue_mixed(80, 20);
    begin_phase(1'b1, 4'd3, 4'd0, 4'd0);
    queue_mixed(120, 20);
    begin_phase(1'b1, 4'd4, 4'd15, 4'd15);
    queue_mixed(120, 20);
    begin_phase(1'b1, 4'd4, 4'd1, 4'd8);
    steady_flow = 1'b1;
    queue_mixed(100, 20);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** adaptive_worker_count_governor_top: PASSED **");
    end else begin
      $display("** adaptive_worker_count_governor_top: FAILED **");
    end
    $finish;
  end

endmodule
